[rtl/core/utcal_pkg.sv]
// ----------------------------------------------------------------------------
// Unix time to calendar fields: shared definitions
// Constants, reciprocal multipliers and the month start table used by the
// calendar conversion pipeline.
// ----------------------------------------------------------------------------
package utcal_pkg;

   localparam int STAGES = 11;

   localparam longint SECS_PER_DAY  = 86400;
   localparam longint SECS_PER_HOUR = 3600;
   localparam longint SECS_PER_MIN  = 60;
   localparam longint DAYS_PER_ERA  = 146097;
   localparam longint EPOCH_SHIFT   = 719468;
   localparam longint DAYS_PER_YEAR = 365;
   localparam longint YEARS_PER_ERA = 400;

   // The time is biased by a whole number of days so that it is never negative.
   localparam longint DAY_BIAS  = 25000;
   localparam longint TIME_BIAS = DAY_BIAS * SECS_PER_DAY;

   // Every supported time falls in the era starting in 1600 or the one after it.
   localparam longint ERA_BASE  = 4;
   localparam longint YEAR_BASE = ERA_BASE * YEARS_PER_ERA;
   localparam longint DOE_BIAS  = EPOCH_SHIFT - DAY_BIAS - ERA_BASE * DAYS_PER_ERA;
   localparam longint ERA_SPLIT = (ERA_BASE + 1) * DAYS_PER_ERA - (EPOCH_SHIFT - DAY_BIAS);
   localparam longint LAST_DOE  = DAYS_PER_ERA - 1;

   // 1970-01-01 was a Thursday, which is 3 when Monday is 0.
   localparam longint WD_BIAS = ((3 - DAY_BIAS) % 7 + 7) % 7;

   // 86400 is 675 shifted left by 7.
   localparam int     DAY_LO_BITS = 7;
   localparam longint DAY_ODD     = 675;

   // Reciprocals: for an N-bit value and divisor d, S = N + ceil(log2(d)) and
   // M = ceil(2**S / d) give an exact floor quotient as (x * M) >> S.
   localparam int     DAY_S  = 36;
   localparam longint DAY_M  = ((64'd1 << DAY_S) + DAY_ODD - 1) / DAY_ODD;
   localparam int     HR_S   = 29;
   localparam longint HR_M   = ((64'd1 << HR_S) + SECS_PER_HOUR - 1) / SECS_PER_HOUR;
   localparam int     WK_S   = 20;
   localparam longint WK_M   = ((64'd1 << WK_S) + 7 - 1) / 7;
   localparam int     Q4_S   = 29;
   localparam longint Q4_M   = ((64'd1 << Q4_S) + 1460 - 1) / 1460;
   localparam int     C1_S   = 34;
   localparam longint C1_M   = ((64'd1 << C1_S) + 36524 - 1) / 36524;
   localparam int     MN_S   = 18;
   localparam longint MN_M   = ((64'd1 << MN_S) + SECS_PER_MIN - 1) / SECS_PER_MIN;
   localparam int     YR_S   = 27;
   localparam longint YR_M   = ((64'd1 << YR_S) + DAYS_PER_YEAR - 1) / DAYS_PER_YEAR;
   localparam int     CN_S   = 16;
   localparam longint CN_M   = ((64'd1 << CN_S) + 100 - 1) / 100;
   localparam int     MP_S   = 19;
   localparam longint MP_M   = ((64'd1 << MP_S) + 153 - 1) / 153;

   localparam logic [3:0] MP_JANUARY = 4'd10;

   // First day, counted from March 1, of each month in the March-based year.
   function automatic logic [8:0] month_first(input logic [3:0] mp);
      logic [8:0] res;
      unique case (mp)
         4'd0:    res = 9'd0;
         4'd1:    res = 9'd31;
         4'd2:    res = 9'd61;
         4'd3:    res = 9'd92;
         4'd4:    res = 9'd122;
         4'd5:    res = 9'd153;
         4'd6:    res = 9'd184;
         4'd7:    res = 9'd214;
         4'd8:    res = 9'd245;
         4'd9:    res = 9'd275;
         4'd10:   res = 9'd306;
         4'd11:   res = 9'd337;
         default: res = 9'd0;
      endcase
      return res;
   endfunction

endpackage

[rtl/core/unix_time_to_calendar_fields_top.sv]
// ----------------------------------------------------------------------------
// Unix time to calendar fields
// Converts signed Unix seconds plus a whole-hour offset into Gregorian date,
// time of day, weekday and day of year.
// ----------------------------------------------------------------------------
// The block takes one timestamp per cycle and passes one result out per
// cycle while the result side does not stall. The time is split into days,
// seconds and the civil date by a chain of constant-reciprocal multiplications,
// each followed by a register. A stall on the result side holds the whole
// pipeline and is passed to the request side in the same cycle. The offset
// register is written with csr_wr_en and should only change while no transfer
// is in flight.
module unix_time_to_calendar_fields_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic signed [4:0]  csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_unix_seconds,
   input  logic [9:0]         req_millis,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [10:0]        rsp_year,
   output logic [3:0]         rsp_month,
   output logic [4:0]         rsp_day,
   output logic [4:0]         rsp_hour,
   output logic [5:0]         rsp_minute,
   output logic [5:0]         rsp_second,
   output logic [9:0]         rsp_millisecond,
   output logic [2:0]         rsp_weekday,
   output logic [8:0]         rsp_day_of_year
);
   import utcal_pkg::*;

   logic signed [4:0] offset_ff;
   logic [STAGES:1]   vld_ff;
   logic              advance;

   logic signed [33:0] t_full;
   logic [52:0] prod_day;
   logic [34:0] prod_hr;
   logic [34:0] prod_wk;
   logic [36:0] prod_q4;
   logic [36:0] prod_c1;
   logic [24:0] prod_mn;
   logic [36:0] prod_yr;
   logic [18:0] prod_cn;
   logic [22:0] prod_mp;
   logic [10:0] mp_num;
   logic        era_hi;
   logic        late;

   // Stage 1
   logic [32:0] s1_t_in, s1_t_ff;
   logic [9:0]  s1_ms_in, s1_ms_ff;
   // Stage 2
   logic [15:0] s2_q_in, s2_q_ff;
   logic [32:0] s2_t_ff;
   logic [9:0]  s2_ms_ff;
   // Stage 3
   logic [16:0] s3_sod_in, s3_sod_ff;
   logic [15:0] s3_q_ff;
   logic [9:0]  s3_ms_ff;
   // Stage 4
   logic [17:0] s4_doe_in, s4_doe_ff;
   logic        s4_era_ff;
   logic [4:0]  s4_hr_in, s4_hr_ff;
   logic [16:0] s4_sod_ff;
   logic [16:0] s4_w_in, s4_w_ff;
   logic [9:0]  s4_ms_ff;
   // Stage 5
   logic [6:0]  s5_a_in, s5_a_ff;
   logic [2:0]  s5_c_in, s5_c_ff;
   logic [11:0] s5_r_in, s5_r_ff;
   logic [13:0] s5_wq_in, s5_wq_ff;
   logic [17:0] s5_doe_ff;
   logic        s5_era_ff;
   logic [4:0]  s5_hr_ff;
   logic [16:0] s5_w_ff;
   logic [9:0]  s5_ms_ff;
   // Stage 6
   logic [17:0] s6_num_in, s6_num_ff;
   logic [5:0]  s6_mn_in, s6_mn_ff;
   logic [2:0]  s6_wd_in, s6_wd_ff;
   logic [17:0] s6_doe_ff;
   logic        s6_era_ff;
   logic [4:0]  s6_hr_ff;
   logic [11:0] s6_r_ff;
   logic [9:0]  s6_ms_ff;
   // Stage 7
   logic [8:0]  s7_yoe_in, s7_yoe_ff;
   logic [5:0]  s7_sec_in, s7_sec_ff;
   logic [17:0] s7_doe_ff;
   logic        s7_era_ff;
   logic [4:0]  s7_hr_ff;
   logic [5:0]  s7_mn_ff;
   logic [2:0]  s7_wd_ff;
   logic [9:0]  s7_ms_ff;
   // Stage 8
   logic [1:0]  s8_cen_in, s8_cen_ff;
   logic [8:0]  s8_yoe_ff;
   logic [17:0] s8_doe_ff;
   logic        s8_era_ff;
   logic [4:0]  s8_hr_ff;
   logic [5:0]  s8_mn_ff;
   logic [5:0]  s8_sec_ff;
   logic [2:0]  s8_wd_ff;
   logic [9:0]  s8_ms_ff;
   // Stage 9
   logic [8:0]  s9_doy_in, s9_doy_ff;
   logic        s9_leap_in, s9_leap_ff;
   logic [8:0]  s9_yoe_ff;
   logic        s9_era_ff;
   logic [4:0]  s9_hr_ff;
   logic [5:0]  s9_mn_ff;
   logic [5:0]  s9_sec_ff;
   logic [2:0]  s9_wd_ff;
   logic [9:0]  s9_ms_ff;
   // Stage 10
   logic [3:0]  s10_mp_in, s10_mp_ff;
   logic [8:0]  s10_doy_ff;
   logic        s10_leap_ff;
   logic [8:0]  s10_yoe_ff;
   logic        s10_era_ff;
   logic [4:0]  s10_hr_ff;
   logic [5:0]  s10_mn_ff;
   logic [5:0]  s10_sec_ff;
   logic [2:0]  s10_wd_ff;
   logic [9:0]  s10_ms_ff;
   // Stage 11, the result register
   logic [10:0] rsp_year_in, rsp_year_ff;
   logic [3:0]  rsp_month_in, rsp_month_ff;
   logic [4:0]  rsp_day_in, rsp_day_ff;
   logic [8:0]  rsp_yday_in, rsp_yday_ff;
   logic [4:0]  rsp_hour_ff;
   logic [5:0]  rsp_minute_ff;
   logic [5:0]  rsp_second_ff;
   logic [9:0]  rsp_ms_ff;
   logic [2:0]  rsp_wd_ff;

   assign advance   = !(vld_ff[STAGES] && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         vld_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            offset_ff <= csr_wr_data;
         end
         if (advance) begin
            vld_ff <= {vld_ff[STAGES-1:1], req_valid};
         end
      end
   end

   always_comb begin
      t_full   = 34'(req_unix_seconds) + 34'(offset_ff) * 34'sd3600 + 34'(TIME_BIAS);
      s1_t_in  = t_full[32:0];
      s1_ms_in = (req_millis > 10'd999) ? 10'd999 : req_millis;

      prod_day = 53'(s1_t_ff[32:DAY_LO_BITS]) * 53'(DAY_M);
      s2_q_in  = prod_day[DAY_S+15:DAY_S];

      s3_sod_in = 17'(s2_t_ff - 33'(s2_q_ff) * 33'(SECS_PER_DAY));

      era_hi    = (s3_q_ff >= 16'(ERA_SPLIT));
      s4_doe_in = era_hi ? 18'(32'(s3_q_ff) + 32'(DOE_BIAS) - 32'(DAYS_PER_ERA))
                         : 18'(32'(s3_q_ff) + 32'(DOE_BIAS));
      prod_hr   = 35'(s3_sod_ff) * 35'(HR_M);
      s4_hr_in  = prod_hr[HR_S+4:HR_S];
      s4_w_in   = 17'(s3_q_ff) + 17'(WD_BIAS);

      prod_q4  = 37'(s4_doe_ff) * 37'(Q4_M);
      s5_a_in  = prod_q4[Q4_S+6:Q4_S];
      prod_c1  = 37'(s4_doe_ff) * 37'(C1_M);
      s5_c_in  = prod_c1[C1_S+2:C1_S];
      s5_r_in  = 12'(s4_sod_ff - 17'(s4_hr_ff) * 17'(SECS_PER_HOUR));
      prod_wk  = 35'(s4_w_ff) * 35'(WK_M);
      s5_wq_in = prod_wk[WK_S+13:WK_S];

      s6_num_in = s5_doe_ff - 18'(s5_a_ff) + 18'(s5_c_ff)
                  - ((s5_doe_ff == 18'(LAST_DOE)) ? 18'd1 : 18'd0);
      prod_mn   = 25'(s5_r_ff) * 25'(MN_M);
      s6_mn_in  = prod_mn[MN_S+5:MN_S];
      s6_wd_in  = 3'(s5_w_ff - 17'(s5_wq_ff) * 17'd7);

      prod_yr   = 37'(s6_num_ff) * 37'(YR_M);
      s7_yoe_in = prod_yr[YR_S+8:YR_S];
      s7_sec_in = 6'(s6_r_ff - 12'(s6_mn_ff) * 12'(SECS_PER_MIN));

      prod_cn   = 19'(s7_yoe_ff) * 19'(CN_M);
      s8_cen_in = prod_cn[CN_S+1:CN_S];

      s9_doy_in  = 9'(s8_doe_ff - (18'(s8_yoe_ff) * 18'(DAYS_PER_YEAR)
                   + 18'(s8_yoe_ff[8:2]) - 18'(s8_cen_ff)));
      s9_leap_in = (s8_yoe_ff[1:0] == 2'b00)
                   && ((s8_yoe_ff != 9'(s8_cen_ff) * 9'd100) || (s8_yoe_ff == 9'd0));

      mp_num    = 11'({s9_doy_ff, 2'b00}) + 11'(s9_doy_ff) + 11'd2;
      prod_mp   = 23'(mp_num) * 23'(MP_M);
      s10_mp_in = prod_mp[MP_S+3:MP_S];

      late         = (s10_mp_ff >= MP_JANUARY);
      rsp_year_in  = 11'(YEAR_BASE) + 11'(s10_yoe_ff)
                     + (s10_era_ff ? 11'(YEARS_PER_ERA) : 11'd0) + (late ? 11'd1 : 11'd0);
      rsp_month_in = late ? (s10_mp_ff - 4'd9) : (s10_mp_ff + 4'd3);
      rsp_day_in   = 5'(s10_doy_ff - month_first(s10_mp_ff) + 9'd1);
      rsp_yday_in  = late ? (s10_doy_ff - 9'd305)
                          : (s10_doy_ff + 9'd60 + (s10_leap_ff ? 9'd1 : 9'd0));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_t_ff  <= s1_t_in;
         s1_ms_ff <= s1_ms_in;

         s2_q_ff  <= s2_q_in;
         s2_t_ff  <= s1_t_ff;
         s2_ms_ff <= s1_ms_ff;

         s3_sod_ff <= s3_sod_in;
         s3_q_ff   <= s2_q_ff;
         s3_ms_ff  <= s2_ms_ff;

         s4_doe_ff <= s4_doe_in;
         s4_era_ff <= era_hi;
         s4_hr_ff  <= s4_hr_in;
         s4_sod_ff <= s3_sod_ff;
         s4_w_ff   <= s4_w_in;
         s4_ms_ff  <= s3_ms_ff;

         s5_a_ff   <= s5_a_in;
         s5_c_ff   <= s5_c_in;
         s5_r_ff   <= s5_r_in;
         s5_wq_ff  <= s5_wq_in;
         s5_doe_ff <= s4_doe_ff;
         s5_era_ff <= s4_era_ff;
         s5_hr_ff  <= s4_hr_ff;
         s5_w_ff   <= s4_w_ff;
         s5_ms_ff  <= s4_ms_ff;

         s6_num_ff <= s6_num_in;
         s6_mn_ff  <= s6_mn_in;
         s6_wd_ff  <= s6_wd_in;
         s6_doe_ff <= s5_doe_ff;
         s6_era_ff <= s5_era_ff;
         s6_hr_ff  <= s5_hr_ff;
         s6_r_ff   <= s5_r_ff;
         s6_ms_ff  <= s5_ms_ff;

         s7_yoe_ff <= s7_yoe_in;
         s7_sec_ff <= s7_sec_in;
         s7_doe_ff <= s6_doe_ff;
         s7_era_ff <= s6_era_ff;
         s7_hr_ff  <= s6_hr_ff;
         s7_mn_ff  <= s6_mn_ff;
         s7_wd_ff  <= s6_wd_ff;
         s7_ms_ff  <= s6_ms_ff;

         s8_cen_ff <= s8_cen_in;
         s8_yoe_ff <= s7_yoe_ff;
         s8_doe_ff <= s7_doe_ff;
         s8_era_ff <= s7_era_ff;
         s8_hr_ff  <= s7_hr_ff;
         s8_mn_ff  <= s7_mn_ff;
         s8_sec_ff <= s7_sec_ff;
         s8_wd_ff  <= s7_wd_ff;
         s8_ms_ff  <= s7_ms_ff;

         s9_doy_ff  <= s9_doy_in;
         s9_leap_ff <= s9_leap_in;
         s9_yoe_ff  <= s8_yoe_ff;
         s9_era_ff  <= s8_era_ff;
         s9_hr_ff   <= s8_hr_ff;
         s9_mn_ff   <= s8_mn_ff;
         s9_sec_ff  <= s8_sec_ff;
         s9_wd_ff   <= s8_wd_ff;
         s9_ms_ff   <= s8_ms_ff;

         s10_mp_ff   <= s10_mp_in;
         s10_doy_ff  <= s9_doy_ff;
         s10_leap_ff <= s9_leap_ff;
         s10_yoe_ff  <= s9_yoe_ff;
         s10_era_ff  <= s9_era_ff;
         s10_hr_ff   <= s9_hr_ff;
         s10_mn_ff   <= s9_mn_ff;
         s10_sec_ff  <= s9_sec_ff;
         s10_wd_ff   <= s9_wd_ff;
         s10_ms_ff   <= s9_ms_ff;

         rsp_year_ff   <= rsp_year_in;
         rsp_month_ff  <= rsp_month_in;
         rsp_day_ff    <= rsp_day_in;
         rsp_yday_ff   <= rsp_yday_in;
         rsp_hour_ff   <= s10_hr_ff;
         rsp_minute_ff <= s10_mn_ff;
         rsp_second_ff <= s10_sec_ff;
         rsp_ms_ff     <= s10_ms_ff;
         rsp_wd_ff     <= s10_wd_ff;
      end
   end

   assign rsp_valid       = vld_ff[STAGES];
   assign rsp_year        = rsp_year_ff;
   assign rsp_month       = rsp_month_ff;
   assign rsp_day         = rsp_day_ff;
   assign rsp_hour        = rsp_hour_ff;
   assign rsp_minute      = rsp_minute_ff;
   assign rsp_second      = rsp_second_ff;
   assign rsp_millisecond = rsp_ms_ff;
   assign rsp_weekday     = rsp_wd_ff;
   assign rsp_day_of_year = rsp_yday_ff;

endmodule

[rtl/core/utcal_checker.sv]
// ----------------------------------------------------------------------------
// Unix time to calendar fields: port checker
// Checks result ranges, back-pressure, the January day of year and reset behavior seen on the ports.
// ----------------------------------------------------------------------------
module utcal_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [10:0]        rsp_year,
   input logic [3:0]         rsp_month,
   input logic [4:0]         rsp_day,
   input logic [4:0]         rsp_hour,
   input logic [5:0]         rsp_minute,
   input logic [5:0]         rsp_second,
   input logic [9:0]         rsp_millisecond,
   input logic [2:0]         rsp_weekday,
   input logic [8:0]         rsp_day_of_year
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result valid after reset.");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_year) && $stable(rsp_day_of_year)
         && $stable(rsp_second))
      else $error("Stalled result transfer changed.");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("Request stall does not follow the result stall.");

   a_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_month >= 4'd1 && rsp_month <= 4'd12 && rsp_day >= 5'd1
         && rsp_hour < 5'd24 && rsp_minute < 6'd60 && rsp_second < 6'd60
         && rsp_weekday < 3'd7 && rsp_millisecond <= 10'd999
         && rsp_day_of_year >= 9'd1 && rsp_day_of_year <= 9'd366)
      else $error("Result field out of range.");

   a_january: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_month == 4'd1 |-> rsp_day_of_year == {4'd0, rsp_day})
      else $error("Day of year does not match the day in January.");

endmodule

bind unix_time_to_calendar_fields_top utcal_checker u_utcal_checker (.*);
